/* rtl/mpma_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-pattern match automaton package
// Shared constants, port widths and result codes.
// ----------------------------------------------------------------------------
package mpma_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam int NODE_W   = 10;
  localparam int CH_W     = 8;
  localparam int STATUS_W = 2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_STEP   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd2;

endpackage

/* rtl/mpma_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module mpma_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/multi_pattern_match_automaton.sv */
// An insert runs INS_RD and INS_CHK; a step runs STEP, F_RD and F_CHK, with F_FAIL
// and F_RD again per failure-link hop, all through the single child read port.
// The first step after reset or inserts rebuilds the failure links breadth-first,
// scanning every symbol of each queued node and walking failure links per child.
// One word is in flight at a time; ready is high only when idle. After reset the
// child memory, MAX_NODES * 2^SYMBOL_BITS entries, is cleared before the first word.
// ----------------------------------------------------------------------------
// Multi-pattern match automaton
// Builds a pattern trie and steps it as an Aho-Corasick automaton.
// ----------------------------------------------------------------------------
module multi_pattern_match_automaton #(
  parameter int MAX_NODES   = mpma_pkg::MAX_NODES_DEF,
  parameter int SYMBOL_BITS = mpma_pkg::SYMBOL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [mpma_pkg::CH_W-1:0]      ch_i,
  input  logic                           first_i,
  input  logic [mpma_pkg::NODE_W-1:0]    from_node_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mpma_pkg::NODE_W-1:0]    node_o,
  output logic [mpma_pkg::STATUS_W-1:0]  status_o
);

  import mpma_pkg::*;

  localparam int NW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int CW    = NW + 1;
  localparam int SB    = SYMBOL_BITS;
  localparam int AW    = NW + SB;
  localparam int CDEP  = MAX_NODES * (1 << SB);
  localparam int XW    = 17;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_B_INIT  = 4'd4;
  localparam logic [3:0] S_B_POP   = 4'd5;
  localparam logic [3:0] S_B_X     = 4'd6;
  localparam logic [3:0] S_B_FX    = 4'd7;
  localparam logic [3:0] S_B_SCAN  = 4'd8;
  localparam logic [3:0] S_B_Y     = 4'd9;
  localparam logic [3:0] S_B_WR    = 4'd10;
  localparam logic [3:0] S_STEP    = 4'd11;
  localparam logic [3:0] S_F_RD    = 4'd12;
  localparam logic [3:0] S_F_CHK   = 4'd13;
  localparam logic [3:0] S_F_FAIL  = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [CW-1:0]       count_q, count_d;
  logic [NW-1:0]       cur_q, cur_d;
  logic                valid_links_q, valid_links_d;
  logic [SB-1:0]       sym_q, sym_d;
  logic [NODE_W-1:0]   from_q, from_d;
  logic [CW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]       x_q, x_d, fx_q, fx_d, y_q, y_d, t_q, t_d, fres_q, fres_d;
  logic [SB-1:0]       s_q, s_d;
  logic                in_bfs_q, in_bfs_d;
  logic [NODE_W-1:0]   node_q, node_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic              c_we;
  logic [AW-1:0]     c_waddr, c_raddr;
  logic [NW-1:0]     c_wdata, c_rdata;
  logic              f_we;
  logic [NW-1:0]     f_waddr, f_wdata, f_raddr, f_rdata;
  logic              q_we;
  logic [NW-1:0]     q_waddr, q_wdata, q_raddr, q_rdata;
  logic [SB-1:0]     fsym;

  mpma_ram #(.WIDTH(NW), .DEPTH(CDEP)) u_child (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  mpma_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  mpma_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign node_o      = node_q;
  assign status_o    = status_q;
  assign fsym        = in_bfs_q ? s_q : sym_q;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    count_d       = count_q;
    cur_d         = cur_q;
    valid_links_d = valid_links_q;
    sym_d         = sym_q;
    from_d        = from_q;
    head_d        = head_q;
    tail_d        = tail_q;
    x_d           = x_q;
    fx_d          = fx_q;
    y_d           = y_q;
    t_d           = t_q;
    fres_d        = fres_q;
    s_d           = s_q;
    in_bfs_d      = in_bfs_q;
    node_d        = node_q;
    status_d      = status_q;

    c_we    = 1'b0;
    c_waddr = {cur_q, sym_q};
    c_wdata = count_q[NW-1:0];
    c_raddr = {cur_q, sym_q};
    f_we    = 1'b0;
    f_waddr = y_q;
    f_wdata = fres_q;
    f_raddr = t_q;
    q_we    = 1'b0;
    q_waddr = tail_q[NW-1:0];
    q_wdata = y_q;
    q_raddr = head_q[NW-1:0];

    unique case (state_q)
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(CDEP - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d  = ch_i[SB-1:0];
          from_d = from_node_i;
          if (kind_i == KIND_INSERT) begin
            if (first_i) begin
              cur_d = '0;
            end
            state_d = S_INS_RD;
          end else begin
            state_d = valid_links_q ? S_STEP : S_B_INIT;
          end
        end
      end
      S_INS_RD: begin
        state_d = S_INS_CHK;
      end
      S_INS_CHK: begin
        valid_links_d = 1'b0;
        status_d      = ST_OK;
        if (c_rdata != '0) begin
          cur_d  = c_rdata;
          node_d = NODE_W'(c_rdata);
        end else if (count_q < CW'(MAX_NODES)) begin
          c_we    = 1'b1;
          cur_d   = count_q[NW-1:0];
          count_d = count_q + 1'b1;
          node_d  = NODE_W'(count_q[NW-1:0]);
        end else begin
          status_d = ST_FULL;
          node_d   = NODE_W'(cur_q);
        end
        state_d = S_OUT;
      end
      S_B_INIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = '0;
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = '0;
        head_d  = '0;
        tail_d  = CW'(1);
        state_d = S_B_POP;
      end
      S_B_POP: begin
        if (head_q == tail_q || head_q >= CW'(MAX_NODES)) begin
          valid_links_d = 1'b1;
          state_d       = S_STEP;
        end else begin
          head_d  = head_q + 1'b1;
          state_d = S_B_X;
        end
      end
      S_B_X: begin
        x_d     = q_rdata;
        f_raddr = q_rdata;
        state_d = S_B_FX;
      end
      S_B_FX: begin
        fx_d    = f_rdata;
        s_d     = '0;
        state_d = S_B_SCAN;
      end
      S_B_SCAN: begin
        c_raddr = {x_q, s_q};
        state_d = S_B_Y;
      end
      S_B_Y: begin
        y_d = c_rdata;
        if (c_rdata == '0) begin
          s_d     = s_q + 1'b1;
          state_d = (&s_q) ? S_B_POP : S_B_SCAN;
        end else if (x_q == '0) begin
          fres_d  = '0;
          state_d = S_B_WR;
        end else begin
          t_d      = fx_q;
          in_bfs_d = 1'b1;
          state_d  = S_F_RD;
        end
      end
      S_B_WR: begin
        f_we = 1'b1;
        if (tail_q < CW'(MAX_NODES)) begin
          q_we   = 1'b1;
          tail_d = tail_q + 1'b1;
        end
        s_d     = s_q + 1'b1;
        state_d = (&s_q) ? S_B_POP : S_B_SCAN;
      end
      S_STEP: begin
        if (XW'(from_q) >= XW'(count_q)) begin
          node_d   = '0;
          status_d = ST_UNALLOC;
          state_d  = S_OUT;
        end else begin
          t_d      = NW'(from_q);
          in_bfs_d = 1'b0;
          state_d  = S_F_RD;
        end
      end
      S_F_RD: begin
        c_raddr = {t_q, fsym};
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        if (c_rdata != '0 || t_q == '0) begin
          if (in_bfs_q) begin
            fres_d  = c_rdata;
            state_d = S_B_WR;
          end else begin
            node_d   = NODE_W'(c_rdata);
            status_d = ST_OK;
            state_d  = S_OUT;
          end
        end else begin
          state_d = S_F_FAIL;
        end
      end
      S_F_FAIL: begin
        t_d     = f_rdata;
        state_d = S_F_RD;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      clr_q         <= '0;
      count_q       <= CW'(1);
      cur_q         <= '0;
      valid_links_q <= 1'b0;
      in_bfs_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      count_q       <= count_d;
      cur_q         <= cur_d;
      valid_links_q <= valid_links_d;
      in_bfs_q      <= in_bfs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q    <= sym_d;
    from_q   <= from_d;
    head_q   <= head_d;
    tail_q   <= tail_d;
    x_q      <= x_d;
    fx_q     <= fx_d;
    y_q      <= y_d;
    t_q      <= t_d;
    fres_q   <= fres_d;
    s_q      <= s_d;
    node_q   <= node_d;
    status_q <= status_d;
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Multi-pattern match automaton testbench
// Builds pattern tries through insert words and walks them with step words.
// Every result is checked against a local trie and failure-link predictor.
// The run covers directed corner cases, random phases and a saturated trie.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpma_pkg::*;

  localparam int NNODES    = MAX_NODES_DEF;
  localparam int NSYM      = 1 << SYMBOL_BITS_DEF;
  localparam int CYCLE_CAP = 8000000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic [CH_W-1:0]     ch_i;
  logic                first_i;
  logic [NODE_W-1:0]   from_node_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [NODE_W-1:0]   node_o;
  logic [STATUS_W-1:0] status_o;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [STATUS_W-1:0] status;
  } answer_t;

  answer_t pending_answers[$];

  logic [NODE_W-1:0] trie_child [NNODES*NSYM];
  logic [NODE_W-1:0] fail_of [NNODES];
  int                nodes_used;
  logic [NODE_W-1:0] cursor;
  bit                links_fresh;

  int error_count;
  int cycle_count;
  int burst_left;

  multi_pattern_match_automaton dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .ch_i       (ch_i),
    .first_i    (first_i),
    .from_node_i(from_node_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .node_o     (node_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [NODE_W-1:0] walk_fail(logic [NODE_W-1:0] t, logic [7:0] s);
    logic [NODE_W-1:0] c;
    forever begin
      c = trie_child[{t, s}];
      if (c != '0) return c;
      if (t == '0) return '0;
      t = fail_of[t];
    end
  endfunction

  function automatic void relink_trie();
    logic [NODE_W-1:0] bfs[$];
    logic [NODE_W-1:0] x;
    logic [NODE_W-1:0] y;
    bfs.push_back(NODE_W'(0));
    fail_of[0] = '0;
    while (bfs.size() > 0) begin
      x = bfs.pop_front();
      for (int s = 0; s < NSYM; s++) begin
        y = trie_child[{x, s[7:0]}];
        if (y != '0) begin
          fail_of[y] = (x == '0) ? '0 : walk_fail(fail_of[x], s[7:0]);
          bfs.push_back(y);
        end
      end
    end
    links_fresh = 1'b1;
  endfunction

  function automatic answer_t predict_answer(logic k, logic [7:0] c, logic f,
                                             logic [NODE_W-1:0] from);
    answer_t a;
    a.status = ST_OK;
    if (k == KIND_INSERT) begin
      if (f) cursor = '0;
      if (trie_child[{cursor, c}] == '0) begin
        if (nodes_used < NNODES) begin
          trie_child[{cursor, c}] = nodes_used[NODE_W-1:0];
          cursor = nodes_used[NODE_W-1:0];
          nodes_used++;
        end else begin
          a.status = ST_FULL;
        end
      end else begin
        cursor = trie_child[{cursor, c}];
      end
      links_fresh = 1'b0;
      a.node = cursor;
    end else begin
      if (!links_fresh) relink_trie();
      if (from >= nodes_used) begin
        a.node   = '0;
        a.status = ST_UNALLOC;
      end else begin
        a.node = walk_fail(from, c);
      end
    end
    return a;
  endfunction

  task automatic send_word(logic k, logic [7:0] c, logic f, logic [NODE_W-1:0] from,
                           output logic [NODE_W-1:0] next_node);
    answer_t a;
    if (burst_left == 0) begin
      if (in_valid_i) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    ch_i        <= c;
    first_i     <= f;
    from_node_i <= from;
    do @(posedge clk_i); while (!in_ready_o);
    a = predict_answer(k, c, f, from);
    pending_answers.push_back(a);
    next_node = a.node;
    burst_left--;
  endtask

  task automatic drain_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  initial begin
    int mode;
    int left;
    out_ready_i = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (node_o !== want.node) report_mismatch("node", node_o, want.node);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [NODE_W-1:0] n;
    send_word(KIND_STEP, 8'hFF, 1'b1, 10'd0, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd1, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd1023, n);
    send_word(KIND_INSERT, 8'h00, 1'b1, 10'd1023, n);
    send_word(KIND_INSERT, 8'hFF, 1'b0, 10'd0, n);
    send_word(KIND_INSERT, 8'hFF, 1'b1, 10'd0, n);
    send_word(KIND_INSERT, 8'h00, 1'b0, 10'd512, n);
    send_word(KIND_INSERT, 8'h00, 1'b1, 10'd0, n);
    send_word(KIND_INSERT, 8'hFF, 1'b0, 10'd0, n);
    send_word(KIND_STEP, 8'hFF, 1'b0, 10'd2, n);
    send_word(KIND_STEP, 8'hFF, 1'b1, 10'd1, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd3, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd4, n);
    send_word(KIND_STEP, 8'h55, 1'b0, 10'd4, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd5, n);
    send_word(KIND_STEP, 8'hAA, 1'b0, 10'd1023, n);
    send_word(KIND_INSERT, 8'h00, 1'b0, 10'd0, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd6, n);
    send_word(KIND_STEP, 8'h00, 1'b0, 10'd0, n);
    drain_results();
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 9) < 8) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_phases();
    logic [NODE_W-1:0] n;
    logic [NODE_W-1:0] here;
    int plen;
    for (int round = 0; round < 6; round++) begin
      for (int p = 0; p < 6; p++) begin
        plen = $urandom_range(1, 5);
        for (int i = 0; i < plen; i++)
          send_word(KIND_INSERT, pick_symbol(), (i == 0) || ($urandom_range(0, 15) == 0),
                    NODE_W'($urandom_range(0, 1023)), n);
      end
      if (round % 3 == 0) drain_results();
      here = '0;
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 9) == 0) here = NODE_W'($urandom_range(0, 1023));
        send_word(KIND_STEP, pick_symbol(), 1'($urandom_range(0, 1)), here, n);
        here = n;
      end
    end
    drain_results();
  endtask

  task automatic test_trie_full();
    logic [NODE_W-1:0] n;
    int i;
    i = 0;
    while (nodes_used < NNODES) begin
      send_word(KIND_INSERT, 8'($urandom_range(0, 255)), (i % 4) == 0, 10'd0, n);
      i++;
    end
    for (int j = 0; j < 12; j++)
      send_word(KIND_INSERT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                10'd0, n);
    for (int j = 0; j < 20; j++)
      send_word(KIND_STEP, 8'($urandom_range(0, 255)), 1'b0,
                NODE_W'($urandom_range(0, 1023)), n);
    drain_results();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = KIND_INSERT;
    ch_i        = '0;
    first_i     = 1'b0;
    from_node_i = '0;
    error_count = 0;
    cycle_count = 0;
    burst_left  = 0;
    for (int k = 0; k < NNODES*NSYM; k++) trie_child[k] = '0;
    for (int k = 0; k < NNODES; k++) fail_of[k] = '0;
    nodes_used  = 1;
    cursor      = '0;
    links_fresh = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phases();
    test_trie_full();

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
